[rtl/velocity_change_detector_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the velocity change detector
// Shared concurrent checks, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef VELOCITY_CHANGE_DETECTOR_CORE_ASSERT_SVH
`define VELOCITY_CHANGE_DETECTOR_CORE_ASSERT_SVH

// same-cycle implication
`define VCD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vcd check failed");

// next-cycle implication
`define VCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vcd check failed");

`endif

[rtl/vcd_pkg.sv]
// ----------------------------------------------------------------------------
// vcd_pkg
// Shared constants, codes and control structs of the velocity change detector.
// ----------------------------------------------------------------------------
package vcd_pkg;

  localparam int unsigned DEF_WINDOW_DEPTH = 16;
  localparam int unsigned DEF_VEL_WIDTH    = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SAMPLES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THRESHOLD = 2'd1;

  localparam int unsigned WS_W  = 5;
  localparam int unsigned THR_W = 16;
  localparam logic [WS_W-1:0]  WS_RESET  = 5'd6;
  localparam logic [THR_W-1:0] THR_RESET = 16'd41;

  // item kinds on tuser
  localparam int unsigned ACT_W = 2;
  localparam logic [ACT_W-1:0] ACT_SAMPLE     = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SEQ_START  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FULL_RESET = 2'd2;

  localparam int unsigned OUT_FIELDS_W = 4;
  localparam int unsigned OUT_TDATA_W  = 8;

  typedef struct packed {
    logic sample;  // write ring entry and re-sum the window
    logic empty;   // drop window contents
    logic clear;   // drop window contents and rewind write pointer
  } win_cmd_t;

  typedef struct packed {
    logic done;
    logic change;
  } jdg_stat_t;

endpackage

[rtl/velocity_change_detector_core.sv]
// ----------------------------------------------------------------------------
// velocity_change_detector_core
// Windowed mean velocity change detector with stop request and settle report.
//
//   channel   dir  handshake               payload
//   cfg       in   cfg_valid_i/cfg_ready_o cfg_addr_i (register), cfg_data_i
//   s_axis    in   tvalid/tready           tdata velocities+flags, tuser kind
//   m_axis    out  tvalid/tready           tdata result flags
//
// A velocity item that is tested is swept and judged before the next accept:
// the ring sweep reads one RAM entry per cycle over the window fill after the
// item (at most N), then the change test runs eight steps on the shared
// multiplier. A sample without a full window and a reference skips the test.
// Sequence start, full reset and unused kinds go straight to the result. One
// item is in flight; the next is taken while its result still waits in the
// output register, and a finished item stalls while that register is full.
// No clearing pass after reset.
// ----------------------------------------------------------------------------
module velocity_change_detector_core import vcd_pkg::*; #(
  parameter  int unsigned WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter  int unsigned VEL_WIDTH    = DEF_VEL_WIDTH,
  localparam int unsigned IN_TDATA_W   = ((3 * VEL_WIDTH + 2 + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // vel_x, vel_y, vel_z, grasp_active, close_sent, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // action
  input  logic [ACT_W-1:0]       s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // stop_request, stabilized, change_seen, awaiting_stable, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned SUM_W  = VEL_WIDTH + $clog2(WINDOW_DEPTH);
  localparam int unsigned NCNT_W = $clog2(WINDOW_DEPTH + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_JUDGE, ST_DONE} state_e;

  state_e                  state_q;
  logic [WS_W-1:0]         ws_q;
  logic [THR_W-1:0]        thr_q;
  logic [NCNT_W-1:0]       n_eff, fill, stable_inc;
  logic                    accept;
  logic [ACT_W-1:0]        action;
  win_cmd_t                win_cmd;
  logic                    win_done, jdg_start;
  jdg_stat_t               jdg;
  logic signed [SUM_W-1:0] sum [3];
  logic signed [SUM_W-1:0] ref_q [3];
  logic                    grasp_q, close_q;
  logic                    ref_valid_q, waiting_q, stop_sig_q;
  logic [NCNT_W-1:0]       stable_q;
  logic                    res_stop_q, res_stab_q, res_chg_q;
  logic                    out_valid_q;
  logic [OUT_FIELDS_W-1:0] out_data_q;
  logic                    res_load;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign action          = s_axis_tuser_i;
  assign res_load        = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q  <= WS_RESET;
      thr_q <= THR_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_addr_i == REG_WINDOW_SAMPLES) begin
        ws_q <= cfg_data_i[WS_W-1:0];
      end else if (cfg_addr_i == REG_CHANGE_THRESHOLD) begin
        thr_q <= cfg_data_i[THR_W-1:0];
      end
    end
  end

  // zero acts as one, oversize clamps to the ring depth
  always_comb begin
    if (ws_q == '0) begin
      n_eff = NCNT_W'(1);
    end else if (32'(ws_q) > 32'(WINDOW_DEPTH)) begin
      n_eff = NCNT_W'(WINDOW_DEPTH);
    end else begin
      n_eff = NCNT_W'(ws_q);
    end
  end

  assign stable_inc = NCNT_W'(stable_q + 1'b1);

  always_comb begin
    win_cmd.sample = accept && (action == ACT_SAMPLE);
    win_cmd.clear  = accept && (action == ACT_FULL_RESET);
    win_cmd.empty  = (accept && (action == ACT_SEQ_START)) ||
                     ((state_q == ST_JUDGE) && jdg.done && jdg.change && !close_q);
    jdg_start      = (state_q == ST_SWEEP) && win_done && (fill >= n_eff) && ref_valid_q;
  end

  vcd_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .VEL_WIDTH    (VEL_WIDTH)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (win_cmd),
    .wdata_i (s_axis_tdata_i[3*VEL_WIDTH-1:0]),
    .n_i     (n_eff),
    .fill_o  (fill),
    .sum_o   (sum),
    .done_o  (win_done)
  );

  vcd_judge #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .VEL_WIDTH    (VEL_WIDTH)
  ) u_judge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (jdg_start),
    .win_i   (sum),
    .ref_i   (ref_q),
    .thr_i   (thr_q),
    .n_i     (n_eff),
    .stat_o  (jdg)
  );

  // item payload and reference sums
  always_ff @(posedge clk_i) begin
    if (accept) begin
      grasp_q <= s_axis_tdata_i[3*VEL_WIDTH];
      close_q <= s_axis_tdata_i[3*VEL_WIDTH+1];
    end
    if ((state_q == ST_SWEEP && win_done && fill >= n_eff && !ref_valid_q) ||
        (state_q == ST_JUDGE && jdg.done && jdg.change)) begin
      ref_q <= sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ref_valid_q <= 1'b0;
      waiting_q   <= 1'b0;
      stop_sig_q  <= 1'b0;
      stable_q    <= '0;
      res_stop_q  <= 1'b0;
      res_stab_q  <= 1'b0;
      res_chg_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            res_stop_q <= 1'b0;
            res_stab_q <= 1'b0;
            res_chg_q  <= 1'b0;
            case (action)
              ACT_SAMPLE: begin
                state_q <= ST_SWEEP;
              end
              ACT_SEQ_START: begin
                stop_sig_q  <= 1'b0;
                ref_valid_q <= 1'b0;
                state_q     <= ST_DONE;
              end
              ACT_FULL_RESET: begin
                ref_valid_q <= 1'b0;
                waiting_q   <= 1'b0;
                stop_sig_q  <= 1'b0;
                stable_q    <= '0;
                state_q     <= ST_DONE;
              end
              default: begin
                state_q <= ST_DONE;
              end
            endcase
          end
        end
        ST_SWEEP: begin
          if (win_done) begin
            if (fill >= n_eff && ref_valid_q) begin
              state_q <= ST_JUDGE;
            end else begin
              // first full window only loads the reference
              if (fill >= n_eff) begin
                ref_valid_q <= 1'b1;
              end
              state_q <= ST_DONE;
            end
          end
        end
        ST_JUDGE: begin
          if (jdg.done) begin
            res_chg_q <= jdg.change;
            if (jdg.change && !close_q) begin
              if (grasp_q && !stop_sig_q) begin
                res_stop_q <= 1'b1;
                stop_sig_q <= 1'b1;
              end
              waiting_q <= 1'b1;
              stable_q  <= '0;
            end else if (!jdg.change && waiting_q && !close_q) begin
              if (stable_inc >= n_eff) begin
                res_stab_q <= 1'b1;
                waiting_q  <= 1'b0;
                stable_q   <= '0;
                stop_sig_q <= 1'b0;
              end else begin
                stable_q <= stable_inc;
              end
            end
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_load) begin
            out_data_q <= {waiting_q, res_chg_q, res_stab_q, res_stop_q};
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_data_q};

`include "velocity_change_detector_core_assert.svh"

  `VCD_ASSERT_NOW(a_stable_only_waiting, !waiting_q, stable_q == '0)
  `VCD_ASSERT_NOW(a_judge_needs_ref, jdg_start, ref_valid_q)
  `VCD_ASSERT_NOW(a_sweep_done_in_sweep, win_done, state_q == ST_SWEEP)
  `VCD_ASSERT_NOW(a_no_stop_and_settle, out_valid_q, !(out_data_q[0] && out_data_q[1]))
  `VCD_ASSERT_NEXT(a_judge_to_result, state_q == ST_JUDGE && jdg.done, state_q == ST_DONE)

endmodule

[rtl/vcd_ram.sv]
// ----------------------------------------------------------------------------
// vcd_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module vcd_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/vcd_window.sv]
// ----------------------------------------------------------------------------
// vcd_window
// Sample ring in RAM, write pointer, fill count and the per-axis window sums,
// rebuilt newest first by a one-read-per-cycle sweep after each sample.
// ----------------------------------------------------------------------------
module vcd_window import vcd_pkg::*; #(
  parameter  int unsigned WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter  int unsigned VEL_WIDTH    = DEF_VEL_WIDTH,
  localparam int unsigned SUM_W        = VEL_WIDTH + $clog2(WINDOW_DEPTH),
  localparam int unsigned NCNT_W       = $clog2(WINDOW_DEPTH + 1),
  localparam int unsigned ENTRY_W      = 3 * VEL_WIDTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  win_cmd_t                cmd_i,
  input  logic [ENTRY_W-1:0]      wdata_i,
  input  logic [NCNT_W-1:0]       n_i,
  output logic [NCNT_W-1:0]       fill_o,
  output logic signed [SUM_W-1:0] sum_o [3],
  output logic                    done_o
);

  localparam int unsigned PTR_W = $clog2(WINDOW_DEPTH);

  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [NCNT_W-1:0] fill_q, cnt_q;
  logic [NCNT_W-1:0] fill_inc, fill_d;
  logic              issue_q, rvalid_q, rlast_q, done_q;
  logic [ENTRY_W-1:0] rdata;
  logic signed [SUM_W-1:0] sum_q [3];

  vcd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.sample),
    .waddr_i (wr_ptr_q),
    .wdata_i (wdata_i),
    .re_i    (issue_q),
    .raddr_i (rd_ptr_q),
    .rdata_o (rdata)
  );

  always_comb begin
    fill_inc = (fill_q < NCNT_W'(WINDOW_DEPTH)) ? NCNT_W'(fill_q + 1'b1) : fill_q;
    fill_d   = (fill_inc > n_i) ? n_i : fill_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
      cnt_q    <= '0;
      issue_q  <= 1'b0;
      rvalid_q <= 1'b0;
      rlast_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      rvalid_q <= issue_q;
      rlast_q  <= issue_q && (NCNT_W'(cnt_q + 1'b1) == fill_q);
      done_q   <= rvalid_q && rlast_q;
      if (cmd_i.clear) begin
        wr_ptr_q <= '0;
        fill_q   <= '0;
        issue_q  <= 1'b0;
      end else if (cmd_i.empty) begin
        fill_q <= '0;
      end else if (cmd_i.sample) begin
        // newest entry is the one written now
        wr_ptr_q <= (wr_ptr_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
        rd_ptr_q <= wr_ptr_q;
        fill_q   <= fill_d;
        cnt_q    <= '0;
        issue_q  <= 1'b1;
      end else if (issue_q) begin
        rd_ptr_q <= (rd_ptr_q == '0) ? PTR_W'(WINDOW_DEPTH - 1) : PTR_W'(rd_ptr_q - 1'b1);
        cnt_q    <= NCNT_W'(cnt_q + 1'b1);
        if (NCNT_W'(cnt_q + 1'b1) == fill_q) begin
          issue_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sample) begin
      for (int a = 0; a < 3; a++) begin
        sum_q[a] <= '0;
      end
    end else if (rvalid_q) begin
      for (int a = 0; a < 3; a++) begin
        sum_q[a] <= sum_q[a] + SUM_W'(signed'(rdata[a*VEL_WIDTH +: VEL_WIDTH]));
      end
    end
  end

  assign fill_o = fill_q;
  assign sum_o  = sum_q;
  assign done_o = done_q;

endmodule

[rtl/vcd_judge.sv]
// ----------------------------------------------------------------------------
// vcd_judge
// Change test: |window - reference|^2 against (threshold * N)^2, worked out
// on one shared registered multiplier in an eight-step sequence.
// ----------------------------------------------------------------------------
module vcd_judge import vcd_pkg::*; #(
  parameter  int unsigned WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter  int unsigned VEL_WIDTH    = DEF_VEL_WIDTH,
  localparam int unsigned SUM_W        = VEL_WIDTH + $clog2(WINDOW_DEPTH),
  localparam int unsigned NCNT_W       = $clog2(WINDOW_DEPTH + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [SUM_W-1:0] win_i [3],
  input  logic signed [SUM_W-1:0] ref_i [3],
  input  logic [THR_W-1:0]        thr_i,
  input  logic [NCNT_W-1:0]       n_i,
  output jdg_stat_t               stat_o
);

  localparam int unsigned DIFF_W = SUM_W + 1;
  localparam int unsigned T_W    = THR_W + NCNT_W;
  localparam int unsigned MUL_W  = (DIFF_W > T_W) ? DIFF_W : T_W;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned D2_W   = PROD_W + 2;
  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_LAST = 3'd7;

  logic              busy_q, done_q, change_q;
  logic [STEP_W-1:0] step_q;
  logic [1:0]        axis;
  logic signed [DIFF_W-1:0] dif;
  logic [DIFF_W-1:0] mag;
  logic [MUL_W-1:0]  opa_q, opb_q;
  logic [PROD_W-1:0] prod_q;
  logic [D2_W-1:0]   d2_q;

  always_comb begin
    axis = (step_q == 3'd1) ? 2'd1 : ((step_q == 3'd2) ? 2'd2 : 2'd0);
    dif  = DIFF_W'(win_i[axis]) - DIFF_W'(ref_i[axis]);
    mag  = dif[DIFF_W-1] ? DIFF_W'(-dif) : DIFF_W'(dif);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == STEP_LAST);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= STEP_W'(step_q + 1'b1);
        if (step_q == STEP_LAST) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // steps 0..2 square the axis distances, 3..6 form (thr * n)^2, 7 compares
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(opa_q) * PROD_W'(opb_q);
    case (step_q)
      3'd0, 3'd1, 3'd2: begin
        opa_q <= MUL_W'(mag);
        opb_q <= MUL_W'(mag);
      end
      3'd3: begin
        opa_q <= MUL_W'(thr_i);
        opb_q <= MUL_W'(n_i);
      end
      3'd5: begin
        opa_q <= prod_q[MUL_W-1:0];
        opb_q <= prod_q[MUL_W-1:0];
      end
      default: begin
        opa_q <= opa_q;
        opb_q <= opb_q;
      end
    endcase
    if (busy_q) begin
      if (step_q == 3'd2) begin
        d2_q <= D2_W'(prod_q);
      end else if (step_q == 3'd3 || step_q == 3'd4) begin
        d2_q <= d2_q + D2_W'(prod_q);
      end
      if (step_q == STEP_LAST) begin
        change_q <= (d2_q >= D2_W'(prod_q));
      end
    end
  end

  assign stat_o.done   = done_q;
  assign stat_o.change = change_q;

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: velocity change detector testbench
// Drives velocity, sequence start and full reset items through the stream
// input and scores each result item against a cycle-free software model of
// the window sums, change test and settle counter. A short table of directed
// items comes first, then random runs of steady velocity with jumps, under
// several window and threshold settings, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import vcd_pkg::*;

  localparam int unsigned DEPTH         = DEF_WINDOW_DEPTH;
  localparam int unsigned VW            = DEF_VEL_WIDTH;
  localparam int unsigned IN_W          = ((3 * VW + 2 + 7) / 8) * 8;
  localparam int          VEL_MAX       = 2 ** (VW - 1) - 1;
  localparam int          VEL_MIN       = -(2 ** (VW - 1));
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned N_PHASES      = 8;
  localparam int unsigned PHASE_ITEMS   = 55;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned HOLD_AT       = 150;
  localparam int unsigned HOLD_CYCLES   = 400;

  typedef longint unsigned u64_t;
  typedef logic [3*VW-1:0] vel3_t;

  typedef struct packed {
    logic awaiting_stable;
    logic change_seen;
    logic stabilized;
    logic stop_request;
  } det_flags_t;

  typedef enum logic {ROW_ITEM, ROW_REGS} row_kind_e;
  typedef enum int unsigned {
    READY_ALWAYS, READY_COIN, READY_ONE_IN_FOUR, READY_MOSTLY
  } sink_mode_e;

  // for ROW_REGS rows: vx = window_samples, vy = change_threshold
  typedef struct packed {
    row_kind_e        kind;
    logic [ACT_W-1:0] action;
    logic [VW-1:0]    vx;
    logic [VW-1:0]    vy;
    logic [VW-1:0]    vz;
    logic             grasp;
    logic             closed;
    logic             typed;
    det_flags_t       flags;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [25] = '{
    '{ROW_ITEM, ACT_UNUSED,     16'h1234, 16'hEDCB, 16'h0F0F, 1'b1, 1'b1, 1'b1, 4'b0000},
    '{ROW_ITEM, ACT_SAMPLE,     16'h7FFF, 16'h8000, 16'h5555, 1'b1, 1'b0, 1'b1, 4'b0000},
    '{ROW_ITEM, ACT_SAMPLE,     16'h7FFF, 16'h8000, 16'h5555, 1'b1, 1'b0, 1'b1, 4'b0000},
    '{ROW_ITEM, ACT_SAMPLE,     16'h7FFF, 16'h8000, 16'h5555, 1'b1, 1'b0, 1'b1, 4'b0000},
    '{ROW_ITEM, ACT_SAMPLE,     16'h7FFF, 16'h8000, 16'h5555, 1'b1, 1'b0, 1'b1, 4'b0000},
    '{ROW_ITEM, ACT_SAMPLE,     16'h7FFF, 16'h8000, 16'h5555, 1'b1, 1'b0, 1'b1, 4'b0000},
    // first full window only loads the reference
    '{ROW_ITEM, ACT_SAMPLE,     16'h7FFF, 16'h8000, 16'h5555, 1'b1, 1'b0, 1'b1, 4'b0000},
    '{ROW_ITEM, ACT_SAMPLE,     16'h7FFF, 16'h8000, 16'h5555, 1'b1, 1'b0, 1'b1, 4'b0000},
    '{ROW_ITEM, ACT_SAMPLE,     16'h8000, 16'h7FFF, 16'hAAAA, 1'b1, 1'b0, 1'b1, 4'b1101},
    '{ROW_ITEM, ACT_SEQ_START,  16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, 4'b1000},
    '{ROW_ITEM, ACT_FULL_RESET, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 4'b0000},
    '{ROW_REGS, ACT_SAMPLE,     16'd1,    16'd100,  16'h0000, 1'b0, 1'b0, 1'b0, 4'b0000},
    '{ROW_ITEM, ACT_SAMPLE,     16'h0064, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b1, 4'b0000},
    // mean moves by exactly the threshold
    '{ROW_ITEM, ACT_SAMPLE,     16'h00C8, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0, 4'b0000},
    '{ROW_ITEM, ACT_SAMPLE,     16'h00C8, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0, 4'b0000},
    // change once the close command is out
    '{ROW_ITEM, ACT_SAMPLE,     16'hFED4, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0, 4'b0000},
    '{ROW_ITEM, ACT_SAMPLE,     16'hFED4, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 4'b0000},
    '{ROW_ITEM, ACT_SAMPLE,     16'h01F4, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 4'b0000},
    '{ROW_ITEM, ACT_SAMPLE,     16'h01F4, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0, 4'b0000},
    // window of 0 acts as 1, zero threshold: every full window is a change
    '{ROW_REGS, ACT_SAMPLE,     16'd0,    16'd0,    16'h0000, 1'b0, 1'b0, 1'b0, 4'b0000},
    '{ROW_ITEM, ACT_SAMPLE,     16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0, 4'b0000},
    '{ROW_ITEM, ACT_SAMPLE,     16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0, 4'b0000},
    '{ROW_ITEM, ACT_UNUSED,     16'hA5A5, 16'h5A5A, 16'hFFFF, 1'b0, 1'b1, 1'b1, 4'b1000},
    '{ROW_REGS, ACT_SAMPLE,     16'd31,   16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0, 4'b0000},
    '{ROW_ITEM, ACT_SEQ_START,  16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b1, 4'b1000}
  };

  localparam logic [WS_W-1:0] PHASE_WS [N_PHASES] = '{
    5'd31, 5'd6, 5'd16, 5'd1, 5'd2, 5'd0, 5'd4, 5'd10
  };
  localparam logic [THR_W-1:0] PHASE_THR [N_PHASES] = '{
    16'hFFFF, 16'd41, 16'd3000, 16'd0, 16'd1, 16'd300, 16'd20, 16'd150
  };

  logic                   clk_i;
  logic                   rst_ni          = 1'b0;
  logic                   cfg_valid_i     = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_addr_i      = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i      = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_W-1:0]        s_axis_tdata_i  = '0;
  logic [ACT_W-1:0]       s_axis_tuser_i  = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  velocity_change_detector_core DUT (.*);

  // model of the detector state
  logic signed [VW-1:0] ring_m [DEPTH][3];
  int unsigned          wptr_m, fill_m, settle_cnt_m;
  longint               win_sum_m [3];
  longint               base_sum_m [3];
  bit                   base_ok_m, waiting_m, stop_sent_m;
  logic [WS_W-1:0]      ws_m;
  logic [THR_W-1:0]     thr_m;

  det_flags_t  pending_flags_q [$];
  int unsigned fail_cnt     = 0;
  int unsigned results_seen = 0;
  int unsigned burst_left   = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #2ms;
    $display("** velocity_change_detector_core: FAILED **");
    $finish;
  end

  function automatic void clear_tracking();
    wptr_m       = 0;
    fill_m       = 0;
    settle_cnt_m = 0;
    base_ok_m    = 1'b0;
    waiting_m    = 1'b0;
    stop_sent_m  = 1'b0;
    for (int a = 0; a < 3; a++) begin
      win_sum_m[a]  = 0;
      base_sum_m[a] = 0;
    end
  endfunction

  function automatic int unsigned eff_window();
    if (ws_m == 0) return 1;
    if (ws_m > DEPTH) return DEPTH;
    return 32'(ws_m);
  endfunction

  function automatic logic [VW-1:0] sat_vel(input int v);
    if (v > VEL_MAX) v = VEL_MAX;
    else if (v < VEL_MIN) v = VEL_MIN;
    return v[VW-1:0];
  endfunction

  // advances the model by one item and returns the result flags it yields
  function automatic det_flags_t predict_flags(input logic [ACT_W-1:0] act,
                                               input vel3_t vel,
                                               input logic grasp,
                                               input logic closed);
    det_flags_t  f;
    int unsigned n, k;
    int          a, i;
    u64_t        d, d2, t;
    f = '0;
    n = eff_window();
    case (act)
      ACT_FULL_RESET: clear_tracking();
      ACT_SEQ_START: begin
        stop_sent_m = 1'b0;
        base_ok_m   = 1'b0;
        fill_m      = 0;
      end
      ACT_SAMPLE: begin
        for (a = 0; a < 3; a++) ring_m[wptr_m][a] = vel[a*VW +: VW];
        wptr_m = (wptr_m + 1) % DEPTH;
        if (fill_m < DEPTH) fill_m++;
        if (fill_m > n) fill_m = n;
        for (a = 0; a < 3; a++) win_sum_m[a] = 0;
        for (i = 0; i < fill_m; i++) begin
          k = (wptr_m + DEPTH - 1 - i) % DEPTH;
          for (a = 0; a < 3; a++) win_sum_m[a] += ring_m[k][a];
        end
        if (fill_m >= n) begin
          if (!base_ok_m) begin
            base_sum_m = win_sum_m;
            base_ok_m  = 1'b1;
          end else begin
            d2 = 0;
            for (a = 0; a < 3; a++) begin
              d = (win_sum_m[a] >= base_sum_m[a]) ? u64_t'(win_sum_m[a] - base_sum_m[a])
                                                   : u64_t'(base_sum_m[a] - win_sum_m[a]);
              d2 += d * d;
            end
            t = u64_t'(thr_m) * n;
            f.change_seen = (d2 >= t * t);
            if (f.change_seen && !closed) begin
              if (grasp && !stop_sent_m) begin
                f.stop_request = 1'b1;
                stop_sent_m    = 1'b1;
              end
              waiting_m    = 1'b1;
              settle_cnt_m = 0;
              base_sum_m   = win_sum_m;
              fill_m       = 0;
            end else if (f.change_seen) begin
              base_sum_m = win_sum_m;
            end else if (waiting_m && !closed) begin
              settle_cnt_m++;
              if (settle_cnt_m >= n) begin
                f.stabilized = 1'b1;
                waiting_m    = 1'b0;
                settle_cnt_m = 0;
                stop_sent_m  = 1'b0;
              end
            end
          end
        end
      end
      default: ;
    endcase
    f.awaiting_stable = waiting_m;
    return f;
  endfunction

  function automatic void check_flags(input logic [OUT_TDATA_W-1:0] data);
    string      field_name [OUT_FIELDS_W] = '{
      "stop_request", "stabilized", "change_seen", "awaiting_stable"
    };
    det_flags_t got, want;
    got = data[OUT_FIELDS_W-1:0];
    results_seen++;
    if (pending_flags_q.size() == 0) begin
      $error("result item with no item outstanding: tdata %b", data);
      fail_cnt++;
    end else begin
      want = pending_flags_q[0];
      pending_flags_q.delete(0);
      for (int b = 0; b < OUT_FIELDS_W; b++) begin
        if (got[b] !== want[b]) begin
          $error("%s: expected %0b, actual %0b", field_name[b], want[b], got[b]);
          fail_cnt++;
        end
      end
    end
  endfunction

  // called at a clock edge; returns at the edge the item is taken
  task automatic send_item(input logic [ACT_W-1:0] act, input vel3_t vel,
                           input logic grasp, input logic closed,
                           input bit typed = 1'b0, input det_flags_t typed_flags = '0);
    det_flags_t  f;
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
    end
    burst_left--;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= act;
    s_axis_tdata_i  <= IN_W'({closed, grasp, vel});
    do @(posedge clk_i); while (!s_axis_tready_o);
    f = predict_flags(act, vel, grasp, closed);
    pending_flags_q = {pending_flags_q, (typed ? typed_flags : f)};
  endtask

  task automatic write_regs(input logic [WS_W-1:0] ws, input logic [THR_W-1:0] thr);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= REG_WINDOW_SAMPLES;
    cfg_data_i  <= CFG_DATA_W'(ws);
    do @(posedge clk_i); while (!cfg_ready_o);
    ws_m = ws;
    cfg_addr_i <= REG_CHANGE_THRESHOLD;
    cfg_data_i <= thr;
    do @(posedge clk_i); while (!cfg_ready_o);
    thr_m = thr;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (pending_flags_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin : result_sink
    sink_mode_e  mode;
    int unsigned mode_left, tick;
    bit          held;
    logic        rdy;
    mode      = READY_ALWAYS;
    mode_left = 0;
    tick      = 0;
    held      = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) check_flags(m_axis_tdata_o);
      // one long hold-off so the block backs up into its input
      if (!held && results_seen >= HOLD_AT) begin
        held = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (mode_left == 0) begin
        mode      = sink_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(8, 80);
      end
      mode_left--;
      tick++;
      case (mode)
        READY_ALWAYS:      rdy = 1'b1;
        READY_COIN:        rdy = 1'($urandom_range(0, 1));
        READY_ONE_IN_FOUR: rdy = (tick % 4 == 0);
        default:           rdy = ($urandom_range(0, 7) != 0);
      endcase
      m_axis_tready_i <= rdy;
    end
  end

  initial begin : stimulus
    stim_row_t        row;
    logic [WS_W-1:0]  ws;
    logic [THR_W-1:0] thr;
    logic [ACT_W-1:0] act;
    int unsigned      p, n, amp, seg_amp, seg_len, sent, roll;
    int               base [3];
    logic             grasp, closed;
    vel3_t            vel;
    clear_tracking();
    ws_m  = WS_RESET;
    thr_m = THR_RESET;
    base  = '{0, 0, 0};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_ROWS[r]) begin
      row = DIRECTED_ROWS[r];
      if (row.kind == ROW_REGS) begin
        drain();
        write_regs(row.vx[WS_W-1:0], row.vy);
      end else begin
        send_item(row.action, {row.vz, row.vy, row.vx}, row.grasp, row.closed,
                  row.typed, row.flags);
      end
    end

    for (p = 0; p < N_PHASES; p++) begin
      ws  = PHASE_WS[p];
      thr = PHASE_THR[p];
      if (p == N_PHASES - 1) begin
        ws  = WS_W'($urandom_range(3, 15));
        thr = THR_W'($urandom_range(0, 65535));
      end
      drain();
      write_regs(ws, thr);
      n   = eff_window();
      amp = thr_m / 4;
      if (amp > 2000) amp = 2000;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
          // control and stray items with random fields
          if (roll < 4) act = ACT_SEQ_START;
          else if (roll < 7) act = ACT_FULL_RESET;
          else if (roll < 9) act = ACT_UNUSED;
          else act = ACT_W'($urandom_range(0, 3));
          send_item(act, vel3_t'({$urandom, $urandom}), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
          sent++;
        end else begin
          // a steady run around one velocity, noise kept below the threshold
          seg_amp = amp;
          roll    = $urandom_range(0, 99);
          if (roll < 35) begin
            // keep the previous velocity
          end else if (roll < 65) begin
            for (int a = 0; a < 3; a++) base[a] = int'($urandom_range(0, 65535)) + VEL_MIN;
          end else if (roll < 80) begin
            for (int a = 0; a < 3; a++) base[a] = $urandom_range(0, 1) ? VEL_MAX : VEL_MIN;
          end else begin
            // step of about the threshold on one axis, no noise
            seg_amp = 0;
            base[0] = base[0] + ($urandom_range(0, 1) ? 1 : -1)
                      * (int'(thr_m) + int'($urandom_range(0, 2)) - 1);
          end
          grasp   = ($urandom_range(0, 9) < 8);
          closed  = ($urandom_range(0, 9) < 2);
          seg_len = $urandom_range(1, 3 * n + 2);
          if (seg_len > PHASE_ITEMS - sent) seg_len = PHASE_ITEMS - sent;
          repeat (seg_len) begin
            for (int a = 0; a < 3; a++)
              vel[a*VW +: VW] = sat_vel(base[a] + int'($urandom_range(0, 2 * seg_amp))
                                        - int'(seg_amp));
            send_item(ACT_SAMPLE, vel, grasp, closed);
            sent++;
          end
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) $display("** velocity_change_detector_core: PASSED **");
    else $display("** velocity_change_detector_core: FAILED **");
    $finish;
  end

endmodule
